@@ rtl/pfs_pkg.sv @@
package pfs_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REMOTE_DIRECTION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_KIND       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PROBE_MODE       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MODE       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_DROP_CV    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_SWITCH_MA  = 3'd6;

    localparam logic [15:0] SHORT_DROP_RESET   = 16'd250;
    localparam logic [15:0] RANGE_SWITCH_RESET = 16'd450;
    localparam logic [15:0] BLANK_MAX          = 16'hFFFF;

    localparam logic [3:0] DRIVE_STOP = 4'd0;
    localparam logic [3:0] DRIVE_CW   = 4'd15;
    localparam logic [3:0] DRIVE_CCW  = 4'd11;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    localparam logic [1:0] PROBE_BOTH_CURRENT = 2'd0;
    localparam logic [1:0] PROBE_CURRENT_HALL = 2'd1;
    localparam logic [1:0] PROBE_BOTH_HALL    = 2'd2;

    localparam logic [1:0] RANGE_FORCE_LOW  = 2'd0;
    localparam logic [1:0] RANGE_FORCE_HIGH = 2'd1;
    localparam logic [1:0] RANGE_AUTO       = 2'd2;

    localparam logic [2:0] HOST_PATTERN_OFF   = 3'd1;
    localparam logic [2:0] HOST_PATTERN_ON    = 3'd7;
    localparam logic [2:0] HOST_PATTERN_SLEEP = 3'd5;

    localparam logic [1:0] HOST_OFF   = 2'd0;
    localparam logic [1:0] HOST_ON    = 2'd1;
    localparam logic [1:0] HOST_SLEEP = 2'd2;

    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_MOTOR  = 2'd1;
    localparam logic [1:0] FAULT_SUPPLY = 2'd2;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 24;

    typedef struct packed {
        logic [1:0]  module_lines;
        logic        clear_fault;
        logic [15:0] measured_current_ma;
        logic [15:0] measured_voltage_cv;
        logic [15:0] set_voltage_cv;
        logic        setpoint_changed;
        logic        supply_output_on;
        logic        ccw_line;
        logic        cw_line;
        logic [2:0]  host_lines;
    } in_item_t;

    typedef struct packed {
        logic [1:0] direction_status;
        logic [1:0] module_status;
        logic [1:0] host_status;
        logic [1:0] fault_level;
        logic       output_kill_pulse;
        logic       supply_off_pulse;
        logic       supply_enable;
        logic       high_range;
        logic [1:0] probe_sel;
        logic       motor_kind_sel;
        logic [3:0] motor_drive;
    } out_item_t;

    typedef struct packed {
        logic        direction_mode;
        logic [1:0]  remote_direction;
        logic        motor_kind;
        logic [1:0]  probe_mode;
        logic [1:0]  range_mode;
        logic [15:0] short_drop_cv;
        logic [15:0] range_switch_ma;
    } cfg_t;

endpackage

@@ rtl/power_and_short_fault_supervisor_core.sv @@
// Power and short-circuit fault supervisor. Each input word is one 5 ms tick of host power
// lines, local direction lines, supply readings and a fault-clear request; each tick gives
// exactly one result word with the motor, probe, range and supply line levels and the fault,
// host and direction status. A word moves from the input register through the tick update
// into the result register, which presents its result; one word is taken every cycle as
// long as the result side keeps up. The supervisor state (delay and blanking counters,
// fault level, line latches) updates once per word in the tick update. Registers must be
// written through the cfg port only while no word is in flight; the block does not enforce it.
module power_and_short_fault_supervisor_core
    import pfs_pkg::*;
#(
    parameter int unsigned POWER_DELAY_TICKS = 1000,
    parameter int unsigned SHORT_BLANK_TICKS = 250
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // host_lines[2:0], cw_line[3], ccw_line[4], supply_output_on[5], setpoint_changed[6],
    // set_voltage_cv[22:7], measured_voltage_cv[38:23], measured_current_ma[54:39],
    // clear_fault[55], module_lines[57:56], zero fill[63:58]
    input  logic [IN_DATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // motor_drive[3:0], motor_kind_sel[4], probe_sel[6:5], high_range[7], supply_enable[8],
    // supply_off_pulse[9], output_kill_pulse[10], fault_level[12:11], host_status[14:13],
    // module_status[16:15], direction_status[18:17], zero fill[23:19]
    output logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned IN_ITEM_W  = $bits(in_item_t);
    localparam int unsigned OUT_ITEM_W = $bits(out_item_t);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    cfg_t      cfg_reg;
    out_item_t result;
    logic      advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_ITEM_W){1'b0}}, out_item_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction_mode   <= 1'b0;
            cfg_reg.remote_direction <= DIR_STOP;
            cfg_reg.motor_kind       <= 1'b0;
            cfg_reg.probe_mode       <= PROBE_BOTH_CURRENT;
            cfg_reg.range_mode       <= RANGE_FORCE_LOW;
            cfg_reg.short_drop_cv    <= SHORT_DROP_RESET;
            cfg_reg.range_switch_ma  <= RANGE_SWITCH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIRECTION_MODE:   cfg_reg.direction_mode   <= cfg_data[0];
                REG_REMOTE_DIRECTION: cfg_reg.remote_direction <= cfg_data[1:0];
                REG_MOTOR_KIND:       cfg_reg.motor_kind       <= cfg_data[0];
                REG_PROBE_MODE:       cfg_reg.probe_mode       <= cfg_data[1:0];
                REG_RANGE_MODE:       cfg_reg.range_mode       <= cfg_data[1:0];
                REG_SHORT_DROP_CV:    cfg_reg.short_drop_cv    <= cfg_data;
                REG_RANGE_SWITCH_MA:  cfg_reg.range_switch_ma  <= cfg_data;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    pfs_logic #(
        .POWER_DELAY_TICKS (POWER_DELAY_TICKS),
        .SHORT_BLANK_TICKS (SHORT_BLANK_TICKS)
    ) u_logic (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

endmodule

@@ rtl/pfs_logic.sv @@
module pfs_logic
    import pfs_pkg::*;
#(
    parameter int unsigned POWER_DELAY_TICKS = 1000,
    parameter int unsigned SHORT_BLANK_TICKS = 250
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    localparam int unsigned DELAY_W = $clog2(POWER_DELAY_TICKS + 2);
    localparam logic [DELAY_W-1:0] DELAY_LIMIT = DELAY_W'(POWER_DELAY_TICKS);
    localparam logic [15:0] BLANK_LIMIT = 16'(SHORT_BLANK_TICKS);

    logic               host_last_reg,    host_last_next;
    logic               switch_armed_reg, switch_armed_next;
    logic [DELAY_W-1:0] switch_delay_reg, switch_delay_next;
    logic [15:0]        blank_count_reg,  blank_count_next;
    logic [1:0]         fault_reg,        fault_next;
    logic [3:0]         drive_reg,        drive_next;
    logic               kind_next;
    logic [1:0]         probe_reg,        probe_next;
    logic               range_reg,        range_next;
    logic               supply_reg,       supply_next;
    logic [1:0]         host_status_reg,  host_status_next;
    logic [1:0]         direction_reg,    direction_next;
    logic               off_pulse;
    logic               kill_pulse;
    logic [16:0]        drop;
    logic               short_seen;

    always_comb
    begin
        host_last_next    = host_last_reg;
        switch_armed_next = switch_armed_reg;
        switch_delay_next = switch_delay_reg;
        blank_count_next  = blank_count_reg;
        fault_next        = fault_reg;
        drive_next        = drive_reg;
        probe_next        = probe_reg;
        range_next        = range_reg;
        supply_next       = supply_reg;
        host_status_next  = host_status_reg;
        direction_next    = direction_reg;
        off_pulse         = 1'b0;
        kill_pulse        = 1'b0;

        if (cfg.direction_mode)
        begin
            case (cfg.remote_direction)
                DIR_STOP: drive_next = DRIVE_STOP;
                DIR_CW:   drive_next = DRIVE_CW;
                DIR_CCW:  drive_next = DRIVE_CCW;
                default:  drive_next = drive_reg;
            endcase
        end

        kind_next = cfg.motor_kind;

        case (cfg.probe_mode)
            PROBE_BOTH_CURRENT: probe_next = 2'd0;
            PROBE_CURRENT_HALL: probe_next = 2'd1;
            PROBE_BOTH_HALL:    probe_next = 2'd3;
            default:            probe_next = probe_reg;
        endcase

        case (cfg.range_mode)
            RANGE_FORCE_LOW:  range_next = 1'b0;
            RANGE_FORCE_HIGH: range_next = 1'b1;
            RANGE_AUTO:       range_next = item.measured_current_ma > cfg.range_switch_ma;
            default:          range_next = range_reg;
        endcase

        case (item.host_lines)
            HOST_PATTERN_OFF:
            begin
                if (host_last_reg)
                begin
                    switch_armed_next = 1'b1;
                    host_last_next    = 1'b0;
                    switch_delay_next = '0;
                end
                if (switch_armed_next)
                begin
                    switch_delay_next = switch_delay_next + 1'b1;
                    if (switch_delay_next > DELAY_LIMIT)
                    begin
                        supply_next       = 1'b0;
                        off_pulse         = 1'b1;
                        switch_armed_next = 1'b0;
                        switch_delay_next = '0;
                    end
                end
                host_status_next = HOST_OFF;
            end
            HOST_PATTERN_ON:
            begin
                if (!host_last_reg)
                begin
                    switch_armed_next = 1'b1;
                    host_last_next    = 1'b1;
                    switch_delay_next = '0;
                end
                if (switch_armed_next)
                begin
                    switch_delay_next = switch_delay_next + 1'b1;
                    if (switch_delay_next > DELAY_LIMIT)
                    begin
                        supply_next       = 1'b1;
                        switch_armed_next = 1'b0;
                        switch_delay_next = '0;
                    end
                end
                host_status_next = HOST_ON;
            end
            HOST_PATTERN_SLEEP:
            begin
                host_status_next = HOST_SLEEP;
            end
            default:
            begin
                host_status_next = host_status_reg;
            end
        endcase

        if (item.clear_fault)
        begin
            fault_next = FAULT_NONE;
        end

        drop       = {1'b0, item.set_voltage_cv} - {1'b0, item.measured_voltage_cv};
        short_seen = 1'b0;

        if (item.supply_output_on)
        begin
            if (blank_count_reg != BLANK_MAX)
            begin
                blank_count_next = blank_count_reg + 16'd1;
            end
            if (item.setpoint_changed)
            begin
                blank_count_next = '0;
            end
            short_seen = (blank_count_next > BLANK_LIMIT) && !drop[16]
                         && (drop[15:0] > cfg.short_drop_cv);
        end
        else
        begin
            blank_count_next = '0;
        end

        if (short_seen)
        begin
            case (fault_next)
                FAULT_NONE:
                begin
                    drive_next     = DRIVE_STOP;
                    direction_next = DIR_STOP;
                    fault_next     = FAULT_MOTOR;
                end
                FAULT_MOTOR:
                begin
                    kill_pulse = 1'b1;
                    fault_next = FAULT_SUPPLY;
                end
                default:
                begin
                    fault_next = fault_next;
                end
            endcase
        end

        if (fault_next == FAULT_NONE)
        begin
            case ({item.ccw_line, item.cw_line})
                2'b00:
                begin
                    drive_next     = DRIVE_STOP;
                    direction_next = DIR_STOP;
                end
                2'b01:
                begin
                    drive_next     = DRIVE_CW;
                    direction_next = DIR_CW;
                end
                2'b10:
                begin
                    drive_next     = DRIVE_CCW;
                    direction_next = DIR_CCW;
                end
                default:
                begin
                    drive_next = drive_next;
                end
            endcase
        end

        result.motor_drive       = drive_next;
        result.motor_kind_sel    = kind_next;
        result.probe_sel         = probe_next;
        result.high_range        = range_next;
        result.supply_enable     = supply_next;
        result.supply_off_pulse  = off_pulse;
        result.output_kill_pulse = kill_pulse;
        result.fault_level       = fault_next;
        result.host_status       = host_status_next;
        result.module_status     = item.module_lines;
        result.direction_status  = direction_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_last_reg    <= 1'b0;
            switch_armed_reg <= 1'b0;
            switch_delay_reg <= '0;
            blank_count_reg  <= '0;
            fault_reg        <= FAULT_NONE;
            drive_reg        <= DRIVE_STOP;
            probe_reg        <= '0;
            range_reg        <= 1'b0;
            supply_reg       <= 1'b0;
            host_status_reg  <= HOST_OFF;
            direction_reg    <= DIR_STOP;
        end
        else if (advance)
        begin
            host_last_reg    <= host_last_next;
            switch_armed_reg <= switch_armed_next;
            switch_delay_reg <= switch_delay_next;
            blank_count_reg  <= blank_count_next;
            fault_reg        <= fault_next;
            drive_reg        <= drive_next;
            probe_reg        <= probe_next;
            range_reg        <= range_next;
            supply_reg       <= supply_next;
            host_status_reg  <= host_status_next;
            direction_reg    <= direction_next;
        end
    end

endmodule
